@@ hdl/sgsu_pkg.sv @@
// ----------------------------------------------------------------------------
// sgsu_pkg: shared types and constants for the surface growth site update block
// Holds the word structs, register indexes and the feedback set table.
// ----------------------------------------------------------------------------
package sgsu_pkg;

    localparam int MaxSites   = 256;
    localparam int HeightBits = 16;
    localparam int AddrBits   = $clog2(MaxSites);
    localparam logic [HeightBits-1:0] HeightMax = {HeightBits{1'b1}};

    localparam logic [2:0] CfgSites     = 3'd0;
    localparam logic [2:0] CfgDeposit   = 3'd1;
    localparam logic [2:0] CfgAvalanche = 3'd2;
    localparam logic [2:0] CfgFeedback  = 3'd3;
    localparam logic [2:0] CfgStyle     = 3'd4;
    localparam logic [2:0] CfgCut       = 3'd5;

    localparam logic [2:0] ActNone      = 3'd0;
    localparam logic [2:0] ActDeposit   = 3'd1;
    localparam logic [2:0] ActAvalanche = 3'd2;
    localparam logic [2:0] ActRead      = 3'd3;
    localparam logic [2:0] ActError     = 3'd4;

    localparam logic [0:0] OpUpdate = 1'b0;

    typedef struct packed {
        logic        op;
        logic [7:0]  site;
        logic [15:0] draw;
    } item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  shape_kind;
        logic [15:0] height;
        logic [7:0]  avalanche_size;
    } result_t;

    // Bit k set means shape kind k is in the feedback set.
    function automatic logic [7:0] feedback_set(input logic [4:0] mode);
        logic [7:0] s;
        case (mode)
            5'd0:  s = 8'h02; 5'd1:  s = 8'h06; 5'd2:  s = 8'h0A; 5'd3:  s = 8'h12;
            5'd4:  s = 8'h22; 5'd5:  s = 8'h42; 5'd6:  s = 8'h0E; 5'd7:  s = 8'h16;
            5'd8:  s = 8'h26; 5'd9:  s = 8'h46; 5'd10: s = 8'h1A; 5'd11: s = 8'h2A;
            5'd12: s = 8'h4A; 5'd13: s = 8'h32; 5'd14: s = 8'h52; 5'd15: s = 8'h62;
            5'd16: s = 8'h1E; 5'd17: s = 8'h2E; 5'd18: s = 8'h4E; 5'd19: s = 8'h36;
            5'd20: s = 8'h56; 5'd21: s = 8'h66; 5'd22: s = 8'h3A; 5'd23: s = 8'h5A;
            5'd24: s = 8'h6A; 5'd25: s = 8'h72; 5'd26: s = 8'h3E; 5'd27: s = 8'h5E;
            5'd28: s = 8'h6E; 5'd29: s = 8'h76; 5'd30: s = 8'h7A;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // Classifies the three-site shape a, b, c around center b; 0 when none.
    function automatic logic [2:0] classify(input logic [HeightBits-1:0] a,
                                            input logic [HeightBits-1:0] b,
                                            input logic [HeightBits-1:0] c);
        logic l_eq, l_up, l_dn, r_eq, r_up, r_dn;
        logic [2:0] k;
        l_eq = (a == b);
        l_up = (a == b + HeightBits'(1)) && (b != HeightMax);
        l_dn = (b == a + HeightBits'(1)) && (a != HeightMax);
        r_eq = (c == b);
        r_up = (c == b + HeightBits'(1)) && (b != HeightMax);
        r_dn = (b == c + HeightBits'(1)) && (c != HeightMax);
        if (l_eq && r_eq)                              k = 3'd1;
        else if (l_dn && r_dn)                         k = 3'd2;
        else if (l_up && r_up)                         k = 3'd3;
        else if ((l_eq && r_up) || (l_up && r_eq))     k = 3'd4;
        else if ((l_eq && r_dn) || (l_dn && r_eq))     k = 3'd5;
        else if ((l_dn && r_up) || (l_up && r_dn))     k = 3'd6;
        else                                           k = 3'd0;
        return k;
    endfunction

endpackage

@@ hdl/sgsu_height_ram.sv @@
// ----------------------------------------------------------------------------
// sgsu_height_ram: height store with one write and one registered read port
// ----------------------------------------------------------------------------
module sgsu_height_ram (
    input  logic                              clk,
    input  logic                              we,
    input  logic [sgsu_pkg::AddrBits-1:0]     waddr,
    input  logic [sgsu_pkg::HeightBits-1:0]   wdata,
    input  logic [sgsu_pkg::AddrBits-1:0]     raddr,
    output logic [sgsu_pkg::HeightBits-1:0]   rdata
);

    logic [sgsu_pkg::HeightBits-1:0] mem [sgsu_pkg::MaxSites];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/surface_growth_site_update.sv @@
// ----------------------------------------------------------------------------
// surface_growth_site_update: site update engine for a 1-D growth surface
// Classifies a site's shape, deposits or runs an avalanche, or reads a height.
// ----------------------------------------------------------------------------
// After reset the block first clears the height memory, one site a cycle
// (all MaxSites sites, 256 by default); busy is high during that pass and
// configuration writes are still taken. Every accepted word yields exactly
// one result word, shown for one cycle with done high; the receiver cannot
// stall it. Cost is set by the height memory, with one write and one read
// port, which is read and written one site per cycle. A read or an update
// of an end site only reads the site's height. An interior update reads a
// five-site window and makes a decision; a single deposit then bumps the
// site if it may grow, a repeated deposit runs rounds over the site and
// both neighbors, the last of which changes nothing, and an avalanche walks
// the run left of the site, then the run right of it (stopping at an end of
// the surface), and then lowers both runs.
// ----------------------------------------------------------------------------
module surface_growth_site_update (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  sgsu_pkg::item_t     item,
    output logic                done,
    output sgsu_pkg::result_t   result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int AW = sgsu_pkg::AddrBits;
    localparam int HW = sgsu_pkg::HeightBits;

    // Configuration registers.
    logic [8:0]  sites_reg;
    logic [16:0] dep_chance_reg;
    logic [16:0] av_chance_reg;
    logic [4:0]  fb_mode_reg;
    logic        style_reg;
    logic        cut_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sites_reg      <= 9'd256;
            dep_chance_reg <= 17'd32768;
            av_chance_reg  <= 17'd32768;
            fb_mode_reg    <= 5'd0;
            style_reg      <= 1'b0;
            cut_reg        <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sgsu_pkg::CfgSites:     sites_reg      <= cfg_data[8:0];
                sgsu_pkg::CfgDeposit:   dep_chance_reg <= cfg_data[16:0];
                sgsu_pkg::CfgAvalanche: av_chance_reg  <= cfg_data[16:0];
                sgsu_pkg::CfgFeedback:  fb_mode_reg    <= cfg_data[4:0];
                sgsu_pkg::CfgStyle:     style_reg      <= cfg_data[0];
                sgsu_pkg::CfgCut:       cut_reg        <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Active site count, clamped to the memory depth.
    logic [12:0] n_act;
    assign n_act = (13'(sites_reg) < 13'(sgsu_pkg::MaxSites)) ? 13'(sites_reg)
                                                              : 13'(sgsu_pkg::MaxSites);

    // Feedback set selected by the mode register.
    logic [7:0] fb_set;
    assign fb_set = sgsu_pkg::feedback_set(fb_mode_reg);

    // Memory port.
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [HW-1:0] wdata, rdata;

    sgsu_height_ram u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RD_WAIT, S_RD_DONE,
        S_LOAD0, S_LOAD1, S_LOAD2, S_DECIDE,
        S_DEP_CLS, S_DEP_WR,
        S_AV_LWAIT, S_AV_LCHK, S_AV_RWAIT, S_AV_RCHK,
        S_AV_LDEC_RD, S_AV_LDEC_WR, S_AV_RDEC_RD, S_AV_RDEC_WR,
        S_FINISH
    } state_t;

    state_t        state_reg;
    logic [AW-1:0] cnt_reg;        // clear sweep / walk position
    logic [7:0]    site_reg;
    logic          op_reg;
    logic [15:0]   draw_reg;
    logic [HW-1:0] w_reg [5];      // window h[q-2] .. h[q+2]
    logic [2:0]    load_reg;       // window slots loaded so far
    logic [1:0]    dep_idx_reg;    // which of q-1, q, q+1 is being tried
    logic          progress_reg;
    logic [AW-1:0] left_reg, right_reg;
    logic [HW-1:0] hq_reg;
    logic [2:0]    action_reg, kind_reg;
    logic [HW-1:0] height_reg;
    logic [7:0]    size_reg;
    logic          done_reg;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = '{action: action_reg, shape_kind: kind_reg,
                      height: height_reg[15:0], avalanche_size: size_reg};

    // Window slot s holds site q-2+s; valid where inside 0..n-1.
    function automatic logic slot_ok(input logic [7:0] q, input logic [2:0] s,
                                     input logic [12:0] n);
        logic [12:0] idx;
        idx = 13'(q) + 13'(s);
        return (idx >= 13'd2) && (idx - 13'd2 < n);
    endfunction

    // Deposit eligibility of window center c (1..3): interior and kind 1, 3 or 4.
    logic [1:0]    dc;
    logic [12:0]   didx;
    logic [2:0]    dkind;
    logic          dmay;
    always_comb
    begin
        dc    = dep_idx_reg;
        didx  = 13'(site_reg) + 13'(dc) - 13'd2;
        dkind = sgsu_pkg::classify(w_reg[3'(dc) - 3'd1], w_reg[3'(dc)], w_reg[3'(dc) + 3'd1]);
        dmay  = (didx != 13'd0) && (didx + 13'd1 < n_act) &&
                (dkind == 3'd1 || dkind == 3'd3 || dkind == 3'd4);
    end

    logic [2:0] qkind;
    assign qkind = sgsu_pkg::classify(w_reg[1], w_reg[2], w_reg[3]);

    logic interior;
    assign interior = (site_reg >= 8'd1) && (13'(site_reg) + 13'd1 < n_act);

    // Memory port control.
    always_comb
    begin
        we    = 1'b0;
        waddr = cnt_reg;
        wdata = '0;
        raddr = cnt_reg;
        case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
            end
            S_IDLE:    raddr = AW'(item.site);
            S_RD_WAIT: raddr = AW'(site_reg);
            S_DEP_WR:
            begin
                we    = dmay && (w_reg[3'(dc)] != sgsu_pkg::HeightMax);
                waddr = AW'(13'(site_reg) + 13'(dc) - 13'd2);
                wdata = w_reg[3'(dc)] + HW'(1);
            end
            S_DECIDE:
            begin
                we    = 1'b1;          // cut-first write, turned off again here; it is made below
                waddr = AW'(site_reg);
                wdata = (w_reg[2] != '0) ? w_reg[2] - HW'(1) : w_reg[2];
                we    = 1'b0;
            end
            S_AV_LDEC_WR, S_AV_RDEC_WR:
            begin
                we    = 1'b1;
                wdata = rdata - HW'(1);
            end
            S_FINISH:  raddr = AW'(site_reg);
            default: ;
        endcase
        if (state_reg == S_AV_LWAIT && cut_reg && load_reg == 3'd7)
        begin
            we    = 1'b1;
            waddr = AW'(site_reg);
            wdata = hq_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            cnt_reg      <= '0;
            done_reg     <= 1'b0;
            load_reg     <= '0;
            dep_idx_reg  <= '0;
            progress_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    cnt_reg <= cnt_reg + AW'(1);
                    if (cnt_reg == AW'(sgsu_pkg::MaxSites - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        site_reg   <= item.site;
                        op_reg     <= item.op;
                        draw_reg   <= item.draw;
                        action_reg <= sgsu_pkg::ActNone;
                        kind_reg   <= '0;
                        size_reg   <= '0;
                        state_reg  <= S_RD_WAIT;
                    end
                end
                S_RD_WAIT:
                begin
                    if (op_reg != sgsu_pkg::OpUpdate)
                    begin
                        action_reg <= sgsu_pkg::ActRead;
                        state_reg  <= S_RD_DONE;
                    end
                    else if (!interior)
                    begin
                        state_reg <= S_RD_DONE;
                    end
                    else
                    begin
                        load_reg  <= '0;
                        cnt_reg   <= AW'(13'(site_reg) - 13'd2);
                        state_reg <= S_LOAD0;
                    end
                end
                S_RD_DONE:
                begin
                    height_reg <= (13'(site_reg) < n_act) ? rdata : '0;
                    done_reg   <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                // Fill the five-site window, one read per cycle; out-of-range
                // slots read as zero and are never used for decisions.
                S_LOAD0:
                begin
                    cnt_reg   <= cnt_reg + AW'(1);
                    state_reg <= S_LOAD1;
                end
                S_LOAD1:
                begin
                    w_reg[load_reg] <= slot_ok(site_reg, load_reg, n_act) ? rdata : '0;
                    load_reg        <= load_reg + 3'd1;
                    cnt_reg         <= cnt_reg + AW'(1);
                    if (load_reg == 3'd4)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    kind_reg <= qkind;
                    if (qkind == 3'd0)
                    begin
                        action_reg <= sgsu_pkg::ActError;
                        state_reg  <= S_FINISH;
                    end
                    else if (fb_set[qkind])
                    begin
                        if (17'(draw_reg) < dep_chance_reg)
                        begin
                            action_reg   <= sgsu_pkg::ActDeposit;
                            dep_idx_reg  <= style_reg ? 2'd1 : 2'd2;
                            progress_reg <= 1'b0;
                            state_reg    <= S_DEP_WR;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                    else if (17'(draw_reg) < av_chance_reg)
                    begin
                        action_reg <= sgsu_pkg::ActAvalanche;
                        hq_reg     <= (cut_reg && w_reg[2] != '0) ? w_reg[2] - HW'(1)
                                                                  : w_reg[2];
                        load_reg   <= 3'd7;
                        left_reg   <= AW'(site_reg);
                        right_reg  <= AW'(site_reg);
                        state_reg  <= S_AV_LWAIT;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                // Deposit: window copy tracks memory so classification of the
                // next candidate sees earlier bumps of this round.
                S_DEP_WR:
                begin
                    if (we)
                    begin
                        w_reg[3'(dc)] <= w_reg[3'(dc)] + HW'(1);
                    end
                    if (!style_reg)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else if (dep_idx_reg == 2'd3)
                    begin
                        if (progress_reg || we)
                        begin
                            progress_reg <= 1'b0;
                            dep_idx_reg  <= 2'd1;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                    else
                    begin
                        progress_reg <= progress_reg || we;
                        dep_idx_reg  <= dep_idx_reg + 2'd1;
                        state_reg    <= S_DEP_CLS;
                    end
                end
                S_DEP_CLS:
                begin
                    state_reg <= S_DEP_WR;
                end
                // Avalanche walk left: issue read of left-1, then check.
                S_AV_LWAIT:
                begin
                    load_reg <= '0;
                    if (left_reg == '0)
                    begin
                        state_reg <= S_AV_RWAIT;
                        cnt_reg   <= right_reg + AW'(1);
                    end
                    else
                    begin
                        cnt_reg   <= left_reg - AW'(1);
                        state_reg <= S_AV_LCHK;
                        load_reg  <= 3'd1;
                    end
                end
                S_AV_LCHK:
                begin
                    if (load_reg == 3'd1)
                    begin
                        load_reg <= '0;    // data arrives next cycle
                    end
                    else if (rdata > hq_reg)
                    begin
                        left_reg  <= left_reg - AW'(1);
                        state_reg <= S_AV_LWAIT;
                    end
                    else
                    begin
                        state_reg <= S_AV_RWAIT;
                    end
                end
                S_AV_RWAIT:
                begin
                    if (13'(right_reg) + 13'd1 >= n_act)
                    begin
                        cnt_reg   <= left_reg;
                        state_reg <= S_AV_LDEC_RD;
                    end
                    else
                    begin
                        cnt_reg   <= right_reg + AW'(1);
                        load_reg  <= 3'd1;
                        state_reg <= S_AV_RCHK;
                    end
                end
                S_AV_RCHK:
                begin
                    if (load_reg == 3'd1)
                    begin
                        load_reg <= '0;
                    end
                    else if (rdata > hq_reg)
                    begin
                        right_reg <= right_reg + AW'(1);
                        state_reg <= S_AV_RWAIT;
                    end
                    else
                    begin
                        cnt_reg   <= left_reg;
                        state_reg <= S_AV_LDEC_RD;
                    end
                end
                // Lower left run [left, q) then right run (q, right].
                S_AV_LDEC_RD:
                begin
                    if (cnt_reg == AW'(site_reg))
                    begin
                        cnt_reg   <= AW'(site_reg) + AW'(1);
                        state_reg <= S_AV_RDEC_RD;
                    end
                    else
                    begin
                        state_reg <= S_AV_LDEC_WR;
                    end
                end
                S_AV_LDEC_WR:
                begin
                    cnt_reg   <= cnt_reg + AW'(1);
                    state_reg <= S_AV_LDEC_RD;
                end
                S_AV_RDEC_RD:
                begin
                    if (AW'(site_reg) == right_reg ||
                        cnt_reg == right_reg + AW'(1))
                    begin
                        size_reg  <= (right_reg - left_reg > AW'(255)) ? 8'd255
                                     : 8'(right_reg - left_reg);
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_AV_RDEC_WR;
                    end
                end
                S_AV_RDEC_WR:
                begin
                    cnt_reg   <= cnt_reg + AW'(1);
                    state_reg <= S_AV_RDEC_RD;
                end
                S_FINISH:
                begin
                    state_reg <= S_RD_DONE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ dv/surface_growth_site_update_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// surface_growth_site_update_tb: self-checking bench for the site update block
// Drives update and read words under several register settings. An internal
// height profile predicts every result word, and a scoreboard checks each one.
// ----------------------------------------------------------------------------
module surface_growth_site_update_tb;

    // Shape kinds of the three-site neighborhood.
    localparam int KindNone   = 0;
    localparam int KindFlat   = 1;
    localparam int KindPeak   = 2;
    localparam int KindValley = 3;
    localparam int KindStepUp = 4;
    localparam int KindStepDn = 5;
    localparam int KindSlope  = 6;

    localparam int WatchLimit = 20000;
    localparam int PhaseWords = 150;
    localparam int NumPhases  = 13;

    // The scoreboard keeps its own copy of the height profile and registers,
    // predicts one result word per accepted item and checks them in order.
    class sgsu_scoreboard;
        logic [15:0] surface [sgsu_pkg::MaxSites];
        logic [8:0]  sites;
        logic [16:0] deposit_chance;
        logic [16:0] avalanche_chance;
        logic [4:0]  fb_mode;
        logic        multi_deposit;
        logic        cut_first;
        logic [7:0]  fb_table [32];
        sgsu_pkg::result_t expected_q[$];
        int          errors;
        int          checked;
        int          action_count [5];

        function new();
            fb_table = '{8'h02, 8'h06, 8'h0A, 8'h12, 8'h22, 8'h42, 8'h0E, 8'h16,
                         8'h26, 8'h46, 8'h1A, 8'h2A, 8'h4A, 8'h32, 8'h52, 8'h62,
                         8'h1E, 8'h2E, 8'h4E, 8'h36, 8'h56, 8'h66, 8'h3A, 8'h5A,
                         8'h6A, 8'h72, 8'h3E, 8'h5E, 8'h6E, 8'h76, 8'h7A, 8'h00};
            foreach (surface[i]) surface[i] = '0;
            sites            = 9'd256;
            deposit_chance   = 17'd32768;
            avalanche_chance = 17'd32768;
            fb_mode          = '0;
            multi_deposit    = 1'b0;
            cut_first        = 1'b0;
            errors           = 0;
            checked          = 0;
            foreach (action_count[i]) action_count[i] = 0;
        endfunction

        function void report(string msg);
            $display("%0t ERROR: %s", $realtime, msg);
            errors++;
        endfunction

        function void set_reg(logic [2:0] index, logic [31:0] data);
            case (index)
                sgsu_pkg::CfgSites:     sites            = data[8:0];
                sgsu_pkg::CfgDeposit:   deposit_chance   = data[16:0];
                sgsu_pkg::CfgAvalanche: avalanche_chance = data[16:0];
                sgsu_pkg::CfgFeedback:  fb_mode          = data[4:0];
                sgsu_pkg::CfgStyle:     multi_deposit    = data[0];
                sgsu_pkg::CfgCut:       cut_first        = data[0];
                default: ;
            endcase
        endfunction

        function int active_sites();
            return (sites < sgsu_pkg::MaxSites) ? int'(sites) : sgsu_pkg::MaxSites;
        endfunction

        function int shape_of(int q);
            int dl, dr;
            dl = int'(surface[q-1]) - int'(surface[q]);
            dr = int'(surface[q+1]) - int'(surface[q]);
            if (dl == 0 && dr == 0) return KindFlat;
            if (dl == -1 && dr == -1) return KindPeak;
            if (dl == 1 && dr == 1) return KindValley;
            if ((dl == 0 && dr == 1) || (dl == 1 && dr == 0)) return KindStepUp;
            if ((dl == 0 && dr == -1) || (dl == -1 && dr == 0)) return KindStepDn;
            if ((dl == -1 && dr == 1) || (dl == 1 && dr == -1)) return KindSlope;
            return KindNone;
        endfunction

        // A site grows only if interior, not saturated and flat, valley or step up.
        function bit grow_site(int i, int n);
            int k;
            if (i == 0 || i + 1 >= n) return 1'b0;
            k = shape_of(i);
            if (!(k == KindFlat || k == KindValley || k == KindStepUp)) return 1'b0;
            if (surface[i] == sgsu_pkg::HeightMax) return 1'b0;
            surface[i] = surface[i] + 16'd1;
            return 1'b1;
        endfunction

        function void deposit(int q, int n);
            bit progress;
            if (!multi_deposit) begin
                void'(grow_site(q, n));
                return;
            end
            // Repeat rounds over the site and both neighbors until none grows.
            do begin
                progress = 1'b0;
                for (int o = -1; o <= 1; o++)
                    if (grow_site(q + o, n)) progress = 1'b1;
            end while (progress);
        endfunction

        function int avalanche(int q, int n);
            int lo, hi, size;
            lo = q;
            hi = q;
            if (cut_first && surface[q] != 0) surface[q] = surface[q] - 16'd1;
            while (lo > 0 && surface[lo-1] > surface[q]) lo--;
            while (hi + 1 < n && surface[hi+1] > surface[q]) hi++;
            for (int j = lo; j < q; j++) surface[j] = surface[j] - 16'd1;
            for (int j = q + 1; j <= hi; j++) surface[j] = surface[j] - 16'd1;
            size = hi - lo;
            return (size > 255) ? 255 : size;
        endfunction

        function void note_item(sgsu_pkg::item_t it);
            sgsu_pkg::result_t r;
            int n, q, k;
            n = active_sites();
            q = int'(it.site);
            r = '0;
            r.action = sgsu_pkg::ActNone;
            if (it.op != sgsu_pkg::OpUpdate) begin
                r.action = sgsu_pkg::ActRead;
            end else if (q >= 1 && q + 1 < n) begin
                k = shape_of(q);
                r.shape_kind = 3'(k);
                if (k == KindNone) begin
                    r.action = sgsu_pkg::ActError;
                end else if (fb_table[fb_mode][k]) begin
                    if ({1'b0, it.draw} < deposit_chance) begin
                        deposit(q, n);
                        r.action = sgsu_pkg::ActDeposit;
                    end
                end else if ({1'b0, it.draw} < avalanche_chance) begin
                    r.avalanche_size = 8'(avalanche(q, n));
                    r.action = sgsu_pkg::ActAvalanche;
                end
            end
            if (q < n) r.height = surface[q];
            expected_q = {expected_q, r};
        endfunction

        function void check(sgsu_pkg::result_t got);
            sgsu_pkg::result_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("result word with nothing expected: %p", got));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (want.action < 5) action_count[want.action]++;
            if (got.action !== want.action)
                report($sformatf("action %0d, expected %0d", got.action, want.action));
            if (got.shape_kind !== want.shape_kind)
                report($sformatf("shape_kind %0d, expected %0d",
                                 got.shape_kind, want.shape_kind));
            if (got.height !== want.height)
                report($sformatf("height %0d, expected %0d", got.height, want.height));
            if (got.avalanche_size !== want.avalanche_size)
                report($sformatf("avalanche_size %0d, expected %0d",
                                 got.avalanche_size, want.avalanche_size));
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    sgsu_pkg::item_t   item;
    logic              done;
    sgsu_pkg::result_t result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [2:0]        cfg_index;
    logic [31:0]       cfg_data;

    sgsu_scoreboard board;
    int          quiet_cycles = 0;
    int          idle_pct;

    surface_growth_site_update i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Result words cannot be held off, so every done cycle is checked at the
    // rising edge. The same process watches for a stalled run: any cycle with
    // a handshake on any channel restarts the count.
    always @(posedge clk) begin
        if (rst_n) begin
            if (done) board.check(result);
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WatchLimit) begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("surface_growth_site_update_tb: done, errors");
                $finish;
            end
        end
    end

    task automatic cfg_write(logic [2:0] index, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        board.set_reg(index, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Presents one word and holds it until the block takes it. Start stays
    // high afterwards so back-to-back words need no extra edge.
    task automatic send_word(logic op, logic [7:0] site, logic [15:0] draw);
        @(negedge clk);
        start     <= 1'b1;
        item.op   <= op;
        item.site <= site;
        item.draw <= draw;
        do @(posedge clk); while (busy);
        board.note_item('{op: op, site: site, draw: draw});
    endtask

    task automatic sender_gap(int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Drains every outstanding word and lets the block settle before the
    // registers change.
    task automatic drain();
        sender_gap(1);
        while (board.expected_q.size() != 0) @(posedge clk);
        while (busy) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_config(int n, int dep, int aval, int mode, bit multi, bit cut);
        cfg_write(sgsu_pkg::CfgSites, 32'(n));
        cfg_write(sgsu_pkg::CfgDeposit, 32'(dep));
        cfg_write(sgsu_pkg::CfgAvalanche, 32'(aval));
        cfg_write(sgsu_pkg::CfgFeedback, 32'(mode));
        cfg_write(sgsu_pkg::CfgStyle, 32'(multi));
        cfg_write(sgsu_pkg::CfgCut, 32'(cut));
    endtask

    function automatic int pick_chance();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 65536;
            default: return $urandom_range(65536);
        endcase
    endfunction

    // Most words are updates on interior sites so the profile builds real
    // structure; the rest hit the ends, sites past the active range, or reads.
    task automatic random_word();
        int n, pick, site;
        logic op;
        n    = board.active_sites();
        pick = $urandom_range(99);
        op   = ($urandom_range(9) == 0) ? ~sgsu_pkg::OpUpdate : sgsu_pkg::OpUpdate;
        if (pick < 5)
            site = $urandom_range(255);
        else if (pick < 12)
            case ($urandom_range(3))
                0:       site = 0;
                1:       site = n - 1;
                2:       site = (n < 256) ? n : 255;
                default: site = (n < 255) ? n + 1 : 254;
            endcase
        else
            site = $urandom_range(n - 2, 1);
        send_word(op, 8'(site), 16'($urandom));
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
            sender_gap($urandom_range(8, 1));
    endtask

    initial begin
        board        = new();
        idle_pct     = 7;
        rst_n        = 1'b0;
        start        = 1'b0;
        item         = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed words at reset settings: reads at both ends, updates on the
        // non-interior ends, a flat deposit, then an avalanche off a peak.
        send_word(~sgsu_pkg::OpUpdate, 8'd0, 16'd0);
        send_word(~sgsu_pkg::OpUpdate, 8'd255, 16'hFFFF);
        send_word(sgsu_pkg::OpUpdate, 8'd0, 16'd0);
        send_word(sgsu_pkg::OpUpdate, 8'd255, 16'd0);
        send_word(sgsu_pkg::OpUpdate, 8'd1, 16'd0);
        send_word(sgsu_pkg::OpUpdate, 8'd1, 16'd0);
        send_word(sgsu_pkg::OpUpdate, 8'd254, 16'hFFFF);
        send_word(sgsu_pkg::OpUpdate, 8'd128, 16'd32767);
        send_word(sgsu_pkg::OpUpdate, 8'd128, 16'd32768);
        drain();

        // Smallest surface with an empty feedback set and sure avalanches, cut first, and
        // repeated deposit; reads past the active range must return zero.
        load_config(3, 65536, 65536, 31, 1'b1, 1'b1);
        send_word(sgsu_pkg::OpUpdate, 8'd1, 16'hFFFF);
        send_word(~sgsu_pkg::OpUpdate, 8'd2, 16'd0);
        send_word(~sgsu_pkg::OpUpdate, 8'd3, 16'd0);
        send_word(sgsu_pkg::OpUpdate, 8'd3, 16'd0);
        drain();
        load_config(6, 65536, 0, 30, 1'b1, 1'b0);
        for (int s = 1; s <= 4; s++) send_word(sgsu_pkg::OpUpdate, 8'(s), 16'hFFFF);
        send_word(sgsu_pkg::OpUpdate, 8'd2, 16'd0);
        send_word(sgsu_pkg::OpUpdate, 8'd3, 16'd0);
        drain();

        for (int p = 0; p < NumPhases; p++) begin
            idle_pct = (p < 4) ? 7 : ((p < 8) ? 84 : 0);
            case (p)
                0:  load_config(3, 65536, 65536, 0, 1'b1, 1'b1);
                1:  load_config(256, 0, 65536, 31, 1'b0, 1'b1);
                2:  load_config(8, 65536, 0, 30, 1'b1, 1'b0);
                default:
                    load_config(($urandom_range(3) == 0) ? 256 : $urandom_range(24, 3),
                                pick_chance(), pick_chance(), $urandom_range(31),
                                1'($urandom), 1'($urandom));
            endcase
            for (int w = 0; w < PhaseWords; w++) begin
                random_word();
                if (p == 5 && w == PhaseWords / 2) drain();
            end
            drain();
        end

        // Let any late or stray result words show up before the verdict.
        repeat (600) @(posedge clk);
        $display("checked %0d result words: %0d none, %0d deposit, %0d avalanche,",
                 board.checked, board.action_count[sgsu_pkg::ActNone],
                 board.action_count[sgsu_pkg::ActDeposit],
                 board.action_count[sgsu_pkg::ActAvalanche]);
        $display("%0d read, %0d shape error, over %0d register settings",
                 board.action_count[sgsu_pkg::ActRead],
                 board.action_count[sgsu_pkg::ActError], NumPhases + 3);
        if (board.errors == 0 && board.expected_q.size() == 0) begin
            $display("surface_growth_site_update_tb: done, clean");
        end else begin
            if (board.expected_q.size() != 0)
                $display("%0d expected result words never came", board.expected_q.size());
            $display("surface_growth_site_update_tb: done, errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/sgsu_pkg.sv
hdl/sgsu_height_ram.sv
hdl/surface_growth_site_update.sv
dv/surface_growth_site_update_tb.sv
